FILE: src/grs_pkg.sv
// package for the group reverse stream unit: sizes, types and state codes
`timescale 1ns / 1ps
package grs_pkg;

  localparam int GROUP_MAX   = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(GROUP_MAX);
  localparam int CNT_W       = $clog2(GROUP_MAX + 1);
  localparam int CFG_W       = 5;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   run_end;
    logic                   list_end;
  } out_word_t;

endpackage

FILE: src/group_reverse_stream_unit.sv
// group reverse stream unit: buffers a group in memory and drains it, reversed when full
//
//  channel  | dir | fields (low bit first)
//  s_axis   | in  | tdata: value[31:0]; tlast: list_last
//  m_axis   | out | tdata: value_out[31:0]; tuser: run_end; tlast: list_end
//  cfg      | in  | cfg_data_i: group_size[4:0], written when cfg_we_i is high
//
// an input word is taken whenever no group is draining; a word that
// completes a group or ends the list starts a drain of n results, one memory
// read per cycle through the single read port while the output queue has room.
// a full group drains in reverse order, a partial one ended by list_last in order.
// reset clears the fill count, drain state and output queue; group_size resets to 1.
// a two-word output queue holds memory reads while m_axis stalls, and reads pause
// when it fills; new input words are taken once the last read of a drain is issued.
`timescale 1ns / 1ps
module group_reverse_stream_unit
  import grs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [VALUE_WIDTH-1:0] s_axis_tdata_i,   // [31:0] value
  input  logic                   s_axis_tlast_i,   // list_last
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [VALUE_WIDTH-1:0] m_axis_tdata_o,   // [31:0] value_out
  output logic                   m_axis_tuser_o,   // [0] run_end
  output logic                   m_axis_tlast_o    // list_end
);

  state_e state_q, state_d;
  logic [CFG_W-1:0]  cfg_q;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  remain_q, remain_d;
  logic [ADDR_W-1:0] rd_addr_q, rd_addr_d;
  logic              rev_q, rev_d;
  logic              last_q, last_d;

  logic [VALUE_WIDTH-1:0] mem_q [GROUP_MAX];
  logic [VALUE_WIDTH-1:0] rd_data_q;
  logic                   pend_q;
  logic                   pend_run_q, pend_list_q;

  out_word_t         fifo_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;

  logic              in_acc, take, rd_en;
  logic [CNT_W-1:0]  eff_size, n_fill;
  logic [2:0]        occ_next;
  out_word_t         push_word;

  // saturate the configured size to 1..GROUP_MAX
  always_comb begin
    if (cfg_q == '0) begin
      eff_size = CNT_W'(1);
    end else if (CNT_W'(cfg_q) > CNT_W'(GROUP_MAX)) begin
      eff_size = CNT_W'(GROUP_MAX);
    end else begin
      eff_size = CNT_W'(cfg_q);
    end
  end

  assign s_axis_tready_o = (state_q == ST_FILL);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign n_fill          = fill_q + CNT_W'(1);
  assign take            = m_axis_tvalid_o && m_axis_tready_i;

  // queue words after this cycle, counting the read in flight
  assign occ_next = 3'(cnt_q) - 3'(take) + 3'(pend_q);

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    remain_d  = remain_q;
    rd_addr_d = rd_addr_q;
    rev_d     = rev_q;
    last_d    = last_q;
    rd_en     = 1'b0;
    unique case (state_q)
      ST_FILL: begin
        if (in_acc) begin
          fill_d = n_fill;
          if (n_fill >= eff_size) begin
            state_d   = ST_DRAIN;
            fill_d    = '0;
            remain_d  = n_fill;
            rd_addr_d = fill_q[ADDR_W-1:0];
            rev_d     = 1'b1;
            last_d    = s_axis_tlast_i;
          end else if (s_axis_tlast_i) begin
            state_d   = ST_DRAIN;
            fill_d    = '0;
            remain_d  = n_fill;
            rd_addr_d = '0;
            rev_d     = 1'b0;
            last_d    = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        rd_en = (occ_next <= 3'd1);
        if (rd_en) begin
          remain_d  = remain_q - CNT_W'(1);
          rd_addr_d = rev_q ? rd_addr_q - ADDR_W'(1) : rd_addr_q + ADDR_W'(1);
          if (remain_q == CNT_W'(1)) begin
            state_d = ST_FILL;
          end
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_FILL;
      cfg_q     <= CFG_W'(1);
      fill_q    <= '0;
      remain_q  <= '0;
      rd_addr_q <= '0;
      rev_q     <= 1'b0;
      last_q    <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      remain_q  <= remain_d;
      rd_addr_q <= rd_addr_d;
      rev_q     <= rev_d;
      last_q    <= last_d;
      pend_q    <= rd_en;
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

  // group store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mem_q[fill_q[ADDR_W-1:0]] <= s_axis_tdata_i;
    end
    if (rd_en) begin
      rd_data_q   <= mem_q[rd_addr_q];
      pend_run_q  <= (remain_q == CNT_W'(1));
      pend_list_q <= (remain_q == CNT_W'(1)) && last_q;
    end
  end

  assign push_word = '{value: rd_data_q, run_end: pend_run_q, list_end: pend_list_q};

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      fifo_q[wr_ptr_q] <= push_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (pend_q) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (take) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(pend_q) - 2'(take);
    end
  end

  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = fifo_q[rd_ptr_q].value;
  assign m_axis_tuser_o  = fifo_q[rd_ptr_q].run_end;
  assign m_axis_tlast_o  = fifo_q[rd_ptr_q].list_end;

`ifndef NO_ASSERTIONS
  // the output queue never overflows
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("output queue count above two");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && (cnt_q == 2'd2) |-> take)
    else $error("read data arrives at a full queue");

  // fill count stays below the store depth between groups
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < CNT_W'(GROUP_MAX))
    else $error("fill count reached store depth");

  // a drain always has words left to read
  a_drain_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |-> remain_q != '0)
    else $error("drain with nothing remaining");

  // after the final read of a drain the unit takes input again
  a_drain_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en && (remain_q == CNT_W'(1)) |=> s_axis_tready_o)
    else $error("drain did not return to fill");
`endif

endmodule
